// ===== rtl/apwfe_pkg.sv =====
package apwfe_pkg;

   localparam int FIFO_DEPTH  = 16;
   localparam int FRAME_BYTES = 4;
   localparam int FRAME_BITS  = FRAME_BYTES * 8;

   localparam int PTR_W   = $clog2(FIFO_DEPTH);
   localparam int CNT_W   = $clog2(FIFO_DEPTH + 1);
   localparam int BITS_W  = 6;
   localparam int PER_W   = 16;
   localparam int SYNC_SHIFT = 2;
   localparam int CD_W    = PER_W + SYNC_SHIFT;
   localparam int BYTE_W  = 8;
   localparam int BIT_W   = 3;
   localparam int CSR_IDX_W = 1;

   localparam logic [BIT_W-1:0] LAST_BIT = 3'd7;

   localparam logic [CSR_IDX_W-1:0] CSR_SHORT_TICKS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_TICKS  = 1'd1;

   localparam logic [PER_W-1:0] SHORT_TICKS_RESET = 16'd1;
   localparam logic [PER_W-1:0] LONG_TICKS_RESET  = 16'd2;

   typedef struct packed {
      logic [CNT_W-1:0]  count;
      logic [BYTE_W-1:0] head_data;
   } fifo_status_type;

endpackage

// ===== rtl/apwfe_byte_fifo.sv =====
module apwfe_byte_fifo
   import apwfe_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [BYTE_W-1:0] push_data,
   input  logic              pop,
   output fifo_status_type   status
);

   logic [BYTE_W-1:0] mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]  head_ff, head_in;
   logic [PTR_W-1:0]  tail_ff, tail_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push) begin
         tail_in  = (tail_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
         count_in = count_ff + 1'b1;
      end else if (pop) begin
         head_in = (head_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : head_ff + 1'b1;
         if (count_ff != '0) begin
            count_in = count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[tail_ff] <= push_data;
      end
   end

   assign status.count     = count_ff;
   assign status.head_data = mem_ff[head_ff];

endmodule

// ===== rtl/ask_pulse_width_frame_encoder_core.sv =====
// channel | ports                                          | dir
// --------+------------------------------------------------+-----
// req     | req_valid req_ready req_type req_data_byte     | in
// rsp     | rsp_valid rsp_ready rsp_line_level             | out
//         | rsp_line_written rsp_busy_res rsp_push_accepted |
// csr     | csr_we csr_index csr_wdata                     | in
//
// one item per cycle while the output register is empty or being drained; each item
// updates state at its accept edge and its result sits in an output register the next cycle
// req_ready is high while the output register is empty or being drained
// synchronous reset clears the queue pointers, frame state and the result valid
module ask_pulse_width_frame_encoder_core
   import apwfe_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_type,
   input  logic [BYTE_W-1:0]    req_data_byte,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_line_level,
   output logic                 rsp_line_written,
   output logic                 rsp_busy_res,
   output logic                 rsp_push_accepted,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [PER_W-1:0]     csr_wdata
);

   logic [PER_W-1:0]  short_ticks_ff, short_ticks_in;
   logic [PER_W-1:0]  long_ticks_ff, long_ticks_in;
   logic [BYTE_W-1:0] shift_ff, shift_in;
   logic [BIT_W-1:0]  bit_ff, bit_in;
   logic [BITS_W-1:0] frame_bits_ff, frame_bits_in;
   logic              half_ff, half_in;
   logic              busy_ff, busy_in;
   logic [CD_W-1:0]   cd_ff, cd_in;
   logic              level_ff, level_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              written_ff, written_in;
   logic              accepted_ff, accepted_in;

   logic              accept;
   logic              push;
   logic              pop;
   logic              load;
   logic              one;
   logic [BYTE_W-1:0] cur_byte;
   logic [CD_W-1:0]   cd_dec;
   logic [CD_W-1:0]   short_cd;
   logic [CD_W-1:0]   long_cd;
   logic [CD_W-1:0]   sync_cd;
   fifo_status_type   fifo_st;

   apwfe_byte_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (req_data_byte),
      .pop       (pop),
      .status    (fifo_st)
   );

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign short_cd  = CD_W'(short_ticks_ff);
   assign long_cd   = CD_W'(long_ticks_ff);
   assign sync_cd   = {long_ticks_ff, {SYNC_SHIFT{1'b0}}};
   assign cd_dec    = (cd_ff == '0) ? '0 : cd_ff - 1'b1;
   assign load      = (bit_ff == '0) && !half_ff;
   assign cur_byte  = load ? fifo_st.head_data : shift_ff;
   assign one       = cur_byte[BYTE_W-1];

   always_comb begin
      short_ticks_in = short_ticks_ff;
      long_ticks_in  = long_ticks_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SHORT_TICKS: short_ticks_in = csr_wdata;
            CSR_LONG_TICKS:  long_ticks_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      shift_in      = shift_ff;
      bit_in        = bit_ff;
      frame_bits_in = frame_bits_ff;
      half_in       = half_ff;
      busy_in       = busy_ff;
      cd_in         = cd_ff;
      level_in      = level_ff;
      written_in    = 1'b0;
      accepted_in   = 1'b0;
      push          = 1'b0;
      pop           = 1'b0;
      if (accept) begin
         if (req_type) begin
            if (fifo_st.count != CNT_W'(FIFO_DEPTH)) begin
               push        = 1'b1;
               accepted_in = 1'b1;
               if (!busy_ff) begin
                  cd_in   = CD_W'(1);
                  busy_in = 1'b1;
               end
            end
         end else if (busy_ff) begin
            cd_in = cd_dec;
            if (cd_dec == '0) begin
               if (frame_bits_ff < BITS_W'(FRAME_BITS)) begin
                  if (load && fifo_st.count == '0) begin
                     cd_in = CD_W'(1);
                  end else begin
                     shift_in   = cur_byte;
                     written_in = 1'b1;
                     if (half_ff) begin
                        level_in      = 1'b0;
                        half_in       = 1'b0;
                        cd_in         = one ? short_cd : long_cd;
                        frame_bits_in = frame_bits_ff + 1'b1;
                        if (bit_ff >= LAST_BIT) begin
                           bit_in = '0;
                           pop    = 1'b1;
                        end else begin
                           bit_in   = bit_ff + 1'b1;
                           shift_in = {cur_byte[BYTE_W-2:0], 1'b0};
                        end
                     end else begin
                        level_in = 1'b1;
                        half_in  = 1'b1;
                        cd_in    = one ? long_cd : short_cd;
                     end
                  end
               end else if (half_ff) begin
                  if (frame_bits_ff > BITS_W'(FRAME_BITS)) begin
                     half_in       = 1'b0;
                     frame_bits_in = '0;
                     cd_in         = CD_W'(1);
                     if (fifo_st.count == '0) begin
                        busy_in = 1'b0;
                     end
                  end else begin
                     level_in      = 1'b0;
                     written_in    = 1'b1;
                     cd_in         = sync_cd;
                     frame_bits_in = frame_bits_ff + 1'b1;
                  end
               end else begin
                  level_in   = 1'b1;
                  written_in = 1'b1;
                  half_in    = 1'b1;
                  cd_in      = long_cd;
               end
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         short_ticks_ff <= SHORT_TICKS_RESET;
         long_ticks_ff  <= LONG_TICKS_RESET;
         shift_ff       <= '0;
         bit_ff         <= '0;
         frame_bits_ff  <= '0;
         half_ff        <= 1'b0;
         busy_ff        <= 1'b0;
         cd_ff          <= '0;
         level_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         short_ticks_ff <= short_ticks_in;
         long_ticks_ff  <= long_ticks_in;
         shift_ff       <= shift_in;
         bit_ff         <= bit_in;
         frame_bits_ff  <= frame_bits_in;
         half_ff        <= half_in;
         busy_ff        <= busy_in;
         cd_ff          <= cd_in;
         level_ff       <= level_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         written_ff  <= written_in;
         accepted_ff <= accepted_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_line_level    = level_ff;
   assign rsp_line_written  = written_ff;
   assign rsp_busy_res      = busy_ff;
   assign rsp_push_accepted = accepted_ff;

endmodule

// ===== dv/ask_pulse_width_frame_encoder_core_test.sv =====
module ask_pulse_width_frame_encoder_core_test
   import apwfe_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic KIND_TICK = 1'b0;
   localparam logic KIND_PUSH = 1'b1;
   localparam int   WATCHDOG_LIMIT = 2000;
   localparam int   REPORT_LIMIT = 10;

   typedef struct packed {
      logic level;
      logic written;
      logic busy;
      logic accepted;
   } line_status_type;

   class ask_frame_scoreboard;
      logic [PER_W-1:0]  short_per;
      logic [PER_W-1:0]  long_per;
      logic [BYTE_W-1:0] fifo_mem [FIFO_DEPTH];
      logic [PTR_W-1:0]  head;
      logic [PTR_W-1:0]  tail;
      int                count;
      logic [BYTE_W-1:0] shift_reg;
      int                bit_idx;
      int                frame_bits;
      logic              low_half;
      logic              busy;
      logic              level;
      logic [CD_W-1:0]   countdown;
      line_status_type   line_status_q [$];
      int                mismatches;
      int                effective_items;
      int                pushes;
      int                drops;
      int                frames;
      int                writes;

      function new();
         short_per = SHORT_TICKS_RESET;
         long_per = LONG_TICKS_RESET;
         head = '0;
         tail = '0;
         count = 0;
         shift_reg = '0;
         bit_idx = 0;
         frame_bits = 0;
         low_half = 1'b0;
         busy = 1'b0;
         level = 1'b0;
         countdown = '0;
         mismatches = 0;
         effective_items = 0;
         pushes = 0;
         drops = 0;
         frames = 0;
         writes = 0;
      endfunction

      // one period of the line has run out
      function logic period_elapsed();
         logic one;
         logic wr;
         wr = 1'b0;
         if (frame_bits < FRAME_BITS) begin
            if (bit_idx == 0 && !low_half) begin
               // nothing queued at a byte boundary: retry on the next tick
               if (count == 0) begin
                  countdown = CD_W'(1);
                  return 1'b0;
               end
               shift_reg = fifo_mem[head];
            end
            one = shift_reg[BYTE_W-1];
            if (low_half) begin
               level = 1'b0;
               wr = 1'b1;
               low_half = 1'b0;
               countdown = CD_W'(one ? short_per : long_per);
               frame_bits++;
               if (bit_idx == LAST_BIT) begin
                  bit_idx = 0;
                  head = (head == PTR_W'(FIFO_DEPTH - 1)) ? '0 : head + 1'b1;
                  if (count > 0) count--;
               end else begin
                  bit_idx++;
                  shift_reg = shift_reg << 1;
               end
            end else begin
               level = 1'b1;
               wr = 1'b1;
               low_half = 1'b1;
               countdown = CD_W'(one ? long_per : short_per);
            end
         end else if (low_half) begin
            if (frame_bits > FRAME_BITS) begin
               // end of sync, no line write
               low_half = 1'b0;
               frame_bits = 0;
               countdown = CD_W'(1);
               frames++;
               if (count == 0) busy = 1'b0;
            end else begin
               level = 1'b0;
               wr = 1'b1;
               countdown = {long_per, 2'b00};
               frame_bits++;
            end
         end else begin
            level = 1'b1;
            wr = 1'b1;
            low_half = 1'b1;
            countdown = CD_W'(long_per);
         end
         return wr;
      endfunction

      function void note_item(input logic kind, input logic [BYTE_W-1:0] data);
         line_status_type want;
         want = '0;
         if (kind == KIND_PUSH) begin
            effective_items++;
            pushes++;
            if (count < FIFO_DEPTH) begin
               fifo_mem[tail] = data;
               tail = (tail == PTR_W'(FIFO_DEPTH - 1)) ? '0 : tail + 1'b1;
               count++;
               want.accepted = 1'b1;
               if (!busy) begin
                  countdown = CD_W'(1);
                  busy = 1'b1;
               end
            end else begin
               drops++;
            end
         end else if (busy) begin
            effective_items++;
            if (countdown > 0) countdown--;
            if (countdown == 0) want.written = period_elapsed();
         end
         if (want.written) writes++;
         want.level = level;
         want.busy = busy;
         line_status_q.push_back(want);
      endfunction

      function void check_result(input logic lvl, input logic wr, input logic bsy,
                                 input logic acc);
         line_status_type want;
         if (line_status_q.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("%0t: result with nothing outstanding: level %b written %b",
                        $time, lvl, wr, " busy %b accepted %b", bsy, acc);
            return;
         end
         want = line_status_q.pop_front();
         if (lvl !== want.level || wr !== want.written || bsy !== want.busy
             || acc !== want.accepted) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("%0t: result mismatch: expected level %b written %b busy %b accepted %b",
                        $time, want.level, want.written, want.busy, want.accepted);
               $display("%0t: result mismatch: actual   level %b written %b busy %b accepted %b",
                        $time, lvl, wr, bsy, acc);
            end
         end
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic                 req_type;
   logic [BYTE_W-1:0]    req_data_byte;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic                 rsp_line_level;
   logic                 rsp_line_written;
   logic                 rsp_busy_res;
   logic                 rsp_push_accepted;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [PER_W-1:0]     csr_wdata;

   ask_frame_scoreboard sb;
   logic idle_on;
   int   stall_left;
   int   quiet_cycles;
   int   settings;

   ask_pulse_width_frame_encoder_core uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_data_byte     (req_data_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_line_level    (rsp_line_level),
      .rsp_line_written  (rsp_line_written),
      .rsp_busy_res      (rsp_busy_res),
      .rsp_push_accepted (rsp_push_accepted),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // receiver stalls
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ready = 1'b0;
         stall_left--;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         rsp_ready = 1'b0;
         stall_left = $urandom_range(0, 16);
      end else begin
         rsp_ready = 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_result(rsp_line_level, rsp_line_written, rsp_busy_res, rsp_push_accepted);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("ask_pulse_width_frame_encoder_core_test: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // called at a falling edge, returns at a falling edge
   task automatic send_item(input logic kind, input logic [BYTE_W-1:0] data);
      int gap;
      if (idle_on && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 17);
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_type = kind;
      req_data_byte = data;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_item(kind, data);
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic wait_drained();
      while (sb.line_status_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_periods(input logic [PER_W-1:0] s, input logic [PER_W-1:0] l);
      csr_we = 1'b1;
      csr_index = CSR_SHORT_TICKS;
      csr_wdata = s;
      @(negedge clock);
      csr_index = CSR_LONG_TICKS;
      csr_wdata = l;
      @(negedge clock);
      csr_we = 1'b0;
      sb.short_per = s;
      sb.long_per = l;
      settings++;
   endtask

   // random bursts of pushes, of ticks (the most common) and of mixed items
   task automatic run_traffic(input int count);
      int stop_at;
      int len;
      int pick;
      stop_at = sb.effective_items + count;
      while (sb.effective_items < stop_at) begin
         pick = $urandom_range(0, 9);
         if (pick < 3) begin
            len = $urandom_range(1, 20);
            repeat (len) send_item(KIND_PUSH, BYTE_W'($urandom_range(0, 255)));
         end else if (pick == 3) begin
            len = $urandom_range(1, 12);
            repeat (len) send_item(1'($urandom_range(0, 1)), BYTE_W'($urandom_range(0, 255)));
         end else begin
            len = $urandom_range(1, 80);
            repeat (len) send_item(KIND_TICK, BYTE_W'($urandom_range(0, 255)));
         end
      end
   endtask

   // burn off a countdown longer than 16 ticks, with idle gaps and stalls off
   task automatic burn_countdown();
      logic keep;
      keep = idle_on;
      idle_on = 1'b0;
      while (sb.busy && sb.countdown > 16) send_item(KIND_TICK, BYTE_W'($urandom_range(0, 255)));
      idle_on = keep;
   endtask

   task automatic run_setting(input logic [PER_W-1:0] s, input logic [PER_W-1:0] l,
                              input int count, input logic idle);
      wait_drained();
      write_periods(s, l);
      idle_on = idle;
      run_traffic(count);
      burn_countdown();
   endtask

   initial begin
      sb = new();
      settings = 0;
      quiet_cycles = 0;
      stall_left = 0;
      idle_on = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_type = KIND_TICK;
      req_data_byte = '0;
      rsp_ready = 1'b0;
      csr_we = 1'b0;
      csr_index = CSR_SHORT_TICKS;
      csr_wdata = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      idle_on = 1'b1;

      // ticks while idle, then five edge-case bytes, one more than a frame
      send_item(KIND_TICK, 8'hFF);
      send_item(KIND_TICK, 8'h00);
      send_item(KIND_PUSH, 8'h00);
      send_item(KIND_PUSH, 8'hFF);
      send_item(KIND_PUSH, 8'h80);
      send_item(KIND_PUSH, 8'h01);
      send_item(KIND_PUSH, 8'h7F);
      repeat (16) send_item(KIND_TICK, BYTE_W'($urandom_range(0, 255)));

      run_traffic(180);
      run_setting(16'd1, 16'd1, 180, 1'b1);
      run_setting(16'd0, 16'd0, 120, 1'b1);
      run_setting(16'd3, 16'd1, 150, 1'b1);
      run_setting(16'd2, 16'd5, 150, 1'b0);
      run_setting(PER_W'($urandom_range(1, 6)), PER_W'($urandom_range(1, 6)), 150, 1'b1);
      run_setting(SHORT_TICKS_RESET, LONG_TICKS_RESET, 200, 1'b0);

      // widest periods last, their countdown is left running
      wait_drained();
      write_periods(16'hFFFF, 16'hFFFF);
      run_traffic(40);

      wait_drained();
      repeat (8) @(posedge clock);
      $display("covered %0d active items over %0d period settings: %0d pushes (%0d dropped)",
               sb.effective_items, settings, sb.pushes, sb.drops);
      $display("%0d frames finished, %0d line writes, %0d mismatches",
               sb.frames, sb.writes, sb.mismatches);
      if (sb.mismatches == 0 && sb.line_status_q.size() == 0) begin
         $display("ask_pulse_width_frame_encoder_core_test: clean");
      end else begin
         $display("ask_pulse_width_frame_encoder_core_test: errors");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/apwfe_pkg.sv
rtl/apwfe_byte_fifo.sv
rtl/ask_pulse_width_frame_encoder_core.sv
dv/ask_pulse_width_frame_encoder_core_test.sv
